@@ rtl/core/ialu_pkg.sv @@
// Shared types, command codes and helpers for the variable-width integer ALU.
// Used by every module under rtl/core; no dependencies.
package ialu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned WidW  = 7;
  localparam int unsigned DefMaxWidth = 64;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_SDIV = 3'd3,
    CMD_CMP  = 3'd4,
    CMD_CAST = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    PRED_EQ  = 4'd0,
    PRED_NE  = 4'd1,
    PRED_SLT = 4'd2,
    PRED_SLE = 4'd3,
    PRED_SGT = 4'd4,
    PRED_SGE = 4'd5,
    PRED_ULT = 4'd6,
    PRED_ULE = 4'd7,
    PRED_UGT = 4'd8,
    PRED_UGE = 4'd9
  } pred_e;

  // State carried down the divide pipeline.
  typedef struct packed {
    logic             valid;
    logic [2:0]       cmd;
    logic             dz;
    logic             neg;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] res;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] dvs;
  } stage_t;

  function automatic logic [WidW-1:0] clamp_width(logic [WidW-1:0] w,
                                                  logic [WidW-1:0] maxw);
    logic [WidW-1:0] r;
    r = w;
    if (w == '0) r = WidW'(1);
    else if (w > maxw) r = maxw;
    return r;
  endfunction

  function automatic logic [DataW-1:0] mask_of(logic [WidW-1:0] w);
    logic [DataW-1:0] m;
    if (w >= WidW'(DataW)) m = '1;
    else m = (DataW'(1) << w) - DataW'(1);
    return m;
  endfunction

  function automatic logic [DataW-1:0] sext_from(logic [DataW-1:0] v, logic [WidW-1:0] w);
    logic [WidW-1:0]  sh;
    logic [DataW-1:0] t;
    sh = WidW'(DataW) - w;
    t  = v << sh;
    return DataW'($signed(t) >>> sh);
  endfunction

endpackage

@@ rtl/core/ialu_front.sv @@
// Front end: width clamp, sign extension, add/sub/compare/cast, partial
// products and divide operand prep over two register stages. Uses ialu_pkg.
module ialu_front #(
  parameter logic [ialu_pkg::WidW-1:0] MAX_WIDTH = ialu_pkg::WidW'(ialu_pkg::DefMaxWidth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [2:0]                  cmd_i,
  input  logic [3:0]                  pred_i,
  input  logic [ialu_pkg::DataW-1:0]  lhs_i,
  input  logic [ialu_pkg::DataW-1:0]  rhs_i,
  input  logic [ialu_pkg::WidW-1:0]   lhs_width_i,
  input  logic [ialu_pkg::WidW-1:0]   rhs_width_i,
  input  logic [ialu_pkg::WidW-1:0]   result_width_i,
  output ialu_pkg::stage_t            stage_o
);

  localparam int unsigned W = ialu_pkg::DataW;
  localparam int unsigned H = W / 2;

  logic [ialu_pkg::WidW-1:0] lw, rw, resw, cw;
  logic [W-1:0] a, b, m, cmask, simple;
  logic cmp;
  logic na, nb;

  logic          valid_q;
  logic [2:0]    cmd_q;
  logic          dz_q, neg_q;
  logic [W-1:0]  mask_q, simple_q, ma_q, mb_q, pp0_q;
  logic [H-1:0]  pp1a_q, pp1b_q;

  ialu_pkg::stage_t stage_d, stage_q;
  logic             stage_valid_q;

  always_comb begin
    lw   = ialu_pkg::clamp_width(lhs_width_i, MAX_WIDTH);
    rw   = ialu_pkg::clamp_width(rhs_width_i, MAX_WIDTH);
    resw = ialu_pkg::clamp_width(result_width_i, MAX_WIDTH);
    cw   = (lw > rw) ? lw : rw;
    a    = ialu_pkg::sext_from(lhs_i, lw);
    b    = ialu_pkg::sext_from(rhs_i, rw);
    m    = ialu_pkg::mask_of(resw);
    cmask = ialu_pkg::mask_of(cw);
    na   = a[W-1];
    nb   = b[W-1];
    case (pred_i)
      ialu_pkg::PRED_EQ:  cmp = (a == b);
      ialu_pkg::PRED_NE:  cmp = (a != b);
      ialu_pkg::PRED_SLT: cmp = ($signed(a) <  $signed(b));
      ialu_pkg::PRED_SLE: cmp = ($signed(a) <= $signed(b));
      ialu_pkg::PRED_SGT: cmp = ($signed(a) >  $signed(b));
      ialu_pkg::PRED_SGE: cmp = ($signed(a) >= $signed(b));
      ialu_pkg::PRED_ULT: cmp = ((a & cmask) <  (b & cmask));
      ialu_pkg::PRED_ULE: cmp = ((a & cmask) <= (b & cmask));
      ialu_pkg::PRED_UGT: cmp = ((a & cmask) >  (b & cmask));
      ialu_pkg::PRED_UGE: cmp = ((a & cmask) >= (b & cmask));
      default:            cmp = 1'b0;
    endcase
    case (cmd_i)
      ialu_pkg::CMD_ADD:  simple = (a + b) & m;
      ialu_pkg::CMD_SUB:  simple = (a - b) & m;
      ialu_pkg::CMD_CMP:  simple = W'(cmp);
      ialu_pkg::CMD_CAST: simple = a & m;
      default:            simple = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q    <= cmd_i;
      mask_q   <= m;
      simple_q <= simple;
      pp0_q    <= W'(a[H-1:0] * b[H-1:0]);
      pp1a_q   <= H'(a[H-1:0] * b[W-1:H]);
      pp1b_q   <= H'(a[W-1:H] * b[H-1:0]);
      ma_q     <= na ? (W'(0) - a) : a;
      mb_q     <= nb ? (W'(0) - b) : b;
      neg_q    <= na ^ nb;
      dz_q     <= (b == '0);
    end
  end

  // Second stage: finish the low half of the product for CMD_MUL, else pass the front result.
  always_comb begin
    stage_d       = '0;
    stage_d.valid = valid_q;
    stage_d.cmd   = cmd_q;
    stage_d.dz    = dz_q;
    stage_d.neg   = neg_q;
    stage_d.mask  = mask_q;
    stage_d.rem   = '0;
    stage_d.quo   = ma_q;
    stage_d.dvs   = mb_q;
    if (cmd_q == ialu_pkg::CMD_MUL) begin
      stage_d.res = (pp0_q + {H'(pp1a_q + pp1b_q), H'(0)}) & mask_q;
    end else begin
      stage_d.res = simple_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (en_i) begin
      stage_valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = stage_valid_q;
  end

endmodule

@@ rtl/core/ialu_div_stage.sv @@
// One restoring-division step: produces one quotient bit per register stage.
// Uses ialu_pkg::stage_t.
module ialu_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  ialu_pkg::stage_t stage_i,
  output ialu_pkg::stage_t stage_o
);

  localparam int unsigned W = ialu_pkg::DataW;

  ialu_pkg::stage_t stage_d, stage_q;
  logic             valid_q;
  logic [W-1:0] r2;

  always_comb begin
    stage_d = stage_i;
    r2      = {stage_i.rem[W-2:0], stage_i.quo[W-1]};
    stage_d.quo = {stage_i.quo[W-2:0], 1'b0};
    if (r2 >= stage_i.dvs) begin
      stage_d.rem    = r2 - stage_i.dvs;
      stage_d.quo[0] = 1'b1;
    end else begin
      stage_d.rem    = r2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

@@ rtl/core/integer_alu_variable_width_unit.sv @@
// Variable-width integer ALU: add, sub, mul, signed div, compare, cast.
// Pipeline: 2 front stages, 64 divide steps, 1 output register.
// Throughput: one transaction per cycle; the 64-step divide pipeline sets the latency.
// A stalled output freezes the whole pipeline; no transaction is lost or repeated.
// Reset (rst_ni, async, active low) clears all valid bits; payload is not reset.
module integer_alu_variable_width_unit #(
  parameter logic [ialu_pkg::WidW-1:0] MAX_WIDTH = ialu_pkg::WidW'(ialu_pkg::DefMaxWidth)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] lhs, [127:64] rhs, [134:128] lhs_width, [141:135] rhs_width,
  // [148:142] result_width, [151:149] zero
  input  logic [151:0] s_axis_tdata,
  // [2:0] command, [6:3] predicate
  input  logic [6:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] result
  output logic [63:0]  m_axis_tdata,
  // [0] status
  output logic         m_axis_tuser
);

  localparam int unsigned W     = ialu_pkg::DataW;
  localparam int unsigned Steps = ialu_pkg::DataW;

  logic en;
  ialu_pkg::stage_t pipe [Steps+1];
  logic [W-1:0] q;
  logic [W-1:0] data_d, data_q;
  logic         stat_d, stat_q, valid_q;

  assign en            = ~(valid_q & ~m_axis_tready);
  assign s_axis_tready = en;

  ialu_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (s_axis_tvalid),
    .cmd_i          (s_axis_tuser[2:0]),
    .pred_i         (s_axis_tuser[6:3]),
    .lhs_i          (s_axis_tdata[63:0]),
    .rhs_i          (s_axis_tdata[127:64]),
    .lhs_width_i    (s_axis_tdata[134:128]),
    .rhs_width_i    (s_axis_tdata[141:135]),
    .result_width_i (s_axis_tdata[148:142]),
    .stage_o        (pipe[0])
  );

  for (genvar i = 0; i < Steps; i++) begin : g_div
    ialu_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (pipe[i]),
      .stage_o (pipe[i+1])
    );
  end

  always_comb begin
    q      = pipe[Steps].neg ? (W'(0) - pipe[Steps].quo) : pipe[Steps].quo;
    data_d = pipe[Steps].res;
    stat_d = 1'b0;
    if (pipe[Steps].cmd == ialu_pkg::CMD_SDIV) begin
      stat_d = pipe[Steps].dz;
      data_d = pipe[Steps].dz ? '0 : (q & pipe[Steps].mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= pipe[Steps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      stat_q <= stat_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = stat_q;

endmodule

@@ tb/testbench.sv @@
// Testbench for integer_alu_variable_width_unit: directed table plus random transactions.
// Depends on ialu_pkg and the unit; self-checking against an internal ALU predictor.
`timescale 1ns / 1ps

module testbench;

  // Codes outside the defined command and predicate sets.
  localparam logic [2:0] CmdSpare6  = 3'd6;
  localparam logic [2:0] CmdSpare7  = 3'd7;
  localparam logic [3:0] PredSpare  = 4'd15;

  typedef struct {
    logic [2:0]  cmd;
    logic [3:0]  pred;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [6:0]  lw;
    logic [6:0]  rw;
    logic [6:0]  resw;
    logic        known;
    logic [63:0] res_exp;
    logic        st_exp;
  } op_t;

  typedef struct {
    logic [63:0] res;
    logic        st;
  } alu_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic [6:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;

  alu_res_t expected_q[$];
  int       n_err = 0;
  int       n_ops = 0;
  int       n_res = 0;
  int       n_dz = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  integer_alu_variable_width_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [6:0] eff_width(logic [6:0] w);
    if (w == 0) return 7'd1;
    if (w > 7'd64) return 7'd64;
    return w;
  endfunction

  function automatic logic [63:0] trunc(logic [63:0] v, logic [6:0] w);
    if (w >= 7'd64) return v;
    return v & ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] widen(logic [63:0] v, logic [6:0] w);
    logic [63:0] t;
    if (w >= 7'd64) return v;
    t = trunc(v, w);
    if (t[w-1]) t = t | ~((64'd1 << w) - 64'd1);
    return t;
  endfunction

  function automatic alu_res_t alu_predict(op_t op);
    alu_res_t    r;
    logic [6:0]  lw, rw, resw, cw;
    logic [63:0] a, b;
    lw = eff_width(op.lw);
    rw = eff_width(op.rw);
    resw = eff_width(op.resw);
    a = widen(op.lhs, lw);
    b = widen(op.rhs, rw);
    cw = (lw > rw) ? lw : rw;
    r.res = '0;
    r.st = 1'b0;
    case (op.cmd)
      ialu_pkg::CMD_ADD: r.res = trunc(a + b, resw);
      ialu_pkg::CMD_SUB: r.res = trunc(a - b, resw);
      ialu_pkg::CMD_MUL: r.res = trunc(a * b, resw);
      ialu_pkg::CMD_SDIV: begin
        if (b == 0) r.st = 1'b1;
        else if (a == 64'h8000_0000_0000_0000 && b == '1) r.res = trunc(a, resw);
        else r.res = trunc(64'($signed(a) / $signed(b)), resw);
      end
      ialu_pkg::CMD_CMP: begin
        case (op.pred)
          ialu_pkg::PRED_EQ:  r.res = 64'(a == b);
          ialu_pkg::PRED_NE:  r.res = 64'(a != b);
          ialu_pkg::PRED_SLT: r.res = 64'($signed(a) < $signed(b));
          ialu_pkg::PRED_SLE: r.res = 64'($signed(a) <= $signed(b));
          ialu_pkg::PRED_SGT: r.res = 64'($signed(a) > $signed(b));
          ialu_pkg::PRED_SGE: r.res = 64'($signed(a) >= $signed(b));
          ialu_pkg::PRED_ULT: r.res = 64'(trunc(a, cw) < trunc(b, cw));
          ialu_pkg::PRED_ULE: r.res = 64'(trunc(a, cw) <= trunc(b, cw));
          ialu_pkg::PRED_UGT: r.res = 64'(trunc(a, cw) > trunc(b, cw));
          ialu_pkg::PRED_UGE: r.res = 64'(trunc(a, cw) >= trunc(b, cw));
          default:  r.res = '0;
        endcase
      end
      ialu_pkg::CMD_CAST: r.res = trunc(a, resw);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR t=%0t result #%0d %s: got %h expected %h", $time, n_res, what, got, want);
    n_err++;
  endtask

  task automatic send_op(op_t op);
    alu_res_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, op.resw, op.rw, op.lw, op.rhs, op.lhs};
    s_axis_tuser <= {op.pred, op.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    p = alu_predict(op);
    if (op.known && (p.res !== op.res_exp || p.st !== op.st_exp))
      $display("NOTE table row %0d: predictor differs from typed value", n_ops);
    if (op.known) begin
      p.res = op.res_exp;
      p.st = op.st_exp;
    end
    expected_q.push_back(p);
    if (p.st) n_dz++;
    n_ops++;
  endtask

  // Drop tvalid right after the last accepted transaction.
  task automatic stop_send();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Output side: random stall, check each transaction against the oldest expectation.
  always @(posedge clk_i) begin
    alu_res_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      n_res++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected", m_axis_tdata, '0);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata !== e.res) report_mismatch("result", m_axis_tdata, e.res);
        if (m_axis_tuser !== e.st) report_mismatch("status", 64'(m_axis_tuser), 64'(e.st));
      end
    end
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  function automatic op_t mk(logic [2:0] c, logic [3:0] p, logic [63:0] l, logic [63:0] r,
                             logic [6:0] lw, logic [6:0] rw, logic [6:0] resw,
                             logic k, logic [63:0] re, logic st);
    op_t o;
    o.cmd = c; o.pred = p; o.lhs = l; o.rhs = r;
    o.lw = lw; o.rw = rw; o.resw = resw;
    o.known = k; o.res_exp = re; o.st_exp = st;
    return o;
  endfunction

  function automatic logic [6:0] rand_width();
    case ($urandom_range(9))
      0: return 7'($urandom_range(127));
      1: return 7'd64;
      2: return 7'd1;
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [63:0] rand_val();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000 >> $urandom_range(63);
      3: v = 64'($urandom_range(3));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    op_t table_ops[$];
    op_t o;
    int  ph;
    table_ops.push_back(mk(ialu_pkg::CMD_ADD, ialu_pkg::PRED_EQ, '1, '1, 64, 64, 64,
                           1, 64'hFFFF_FFFF_FFFF_FFFE, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_ADD, ialu_pkg::PRED_EQ, 64'h7F, 64'h1, 8, 8, 8,
                           1, 64'h80, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_SUB, ialu_pkg::PRED_EQ, 0, 1, 1, 1, 64, 1, 64'h1, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_MUL, ialu_pkg::PRED_EQ, '1, '1, 64, 64, 64,
                           1, 64'h1, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_MUL, ialu_pkg::PRED_EQ, 64'hFF, 64'h3, 8, 8, 16,
                           0, 0, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_SDIV, ialu_pkg::PRED_EQ, 64'd7, 0, 64, 64, 64,
                           1, 0, 1));
    table_ops.push_back(mk(ialu_pkg::CMD_SDIV, ialu_pkg::PRED_EQ, 64'd7, 64'h100, 64, 8, 64,
                           1, 0, 1));
    table_ops.push_back(mk(ialu_pkg::CMD_SDIV, ialu_pkg::PRED_EQ, 64'h8000_0000_0000_0000,
                           '1, 64, 64, 64, 1, 64'h8000_0000_0000_0000, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_SDIV, ialu_pkg::PRED_EQ, 64'h80, 64'hFF, 8, 8, 8,
                           0, 0, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_SDIV, ialu_pkg::PRED_EQ, -64'sd7, 64'd2, 64, 64, 64,
                           0, 0, 0));
    for (int p = 0; p < 16; p += 3)
      table_ops.push_back(mk(ialu_pkg::CMD_CMP, 4'(p), 64'hF0, 64'h0F, 8, 4, 1, 0, 0, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_CMP, ialu_pkg::PRED_UGE, 64'h1, 64'h1, 1, 64, 64,
                           0, 0, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_CMP, PredSpare, 1, 1, 64, 64, 64, 1, 0, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_CAST, ialu_pkg::PRED_EQ, 64'h80, '1, 8, 3, 64,
                           1, 64'hFFFF_FFFF_FFFF_FF80, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_CAST, ialu_pkg::PRED_EQ, '1, 0, 0, 0, 0, 1, 64'h1, 0));
    table_ops.push_back(mk(ialu_pkg::CMD_CAST, ialu_pkg::PRED_EQ, 64'h1234, 0, 127, 0, 127,
                           1, 64'h1234, 0));
    table_ops.push_back(mk(CmdSpare6, ialu_pkg::PRED_EQ, '1, '1, 64, 64, 64, 1, 0, 0));
    table_ops.push_back(mk(CmdSpare7, PredSpare, '1, '1, 127, 127, 127, 1, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_ops[i]) send_op(table_ops[i]);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int i = 0; i < 250; i++) begin
        o = mk(3'($urandom_range(7)), 4'($urandom_range(15)), rand_val(), rand_val(),
               rand_width(), rand_width(), rand_width(), 0, 0, 0);
        if ($urandom_range(9) != 0) o.cmd = 3'($urandom_range(5));
        if (i == 120) begin
          // drain fully before continuing
          stop_send();
          while (expected_q.size() != 0) @(posedge clk_i);
        end
        send_op(o);
      end
    end

    stop_send();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d operations (%0d divide-by-zero) over four idle/stall phases;",
             n_ops, n_dz);
    $display("checked %0d results.", n_res);
    if (n_err == 0 && expected_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
